// ===== sv/sle_pkg.sv =====
// Shared constants and types for the sequential list engine.
package sle_pkg;

  localparam int SLE_CAPACITY = 64;

  localparam int MODE_W   = 3;
  localparam int POS_W    = 7;
  localparam int DATA_W   = 8;
  localparam int STATUS_W = 3;
  localparam int LEN_W    = 7;

  localparam logic [MODE_W-1:0] MODE_GET    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_LOCATE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_INSERT = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DELETE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_GET  = 6'b000010,
    S_SCAN = 6'b000100,
    S_UP   = 6'b001000,
    S_DOWN = 6'b010000,
    S_DONE = 6'b100000
  } sle_state_t;

endpackage

// ===== sv/sle_in_if.sv =====
// Request and result channel interfaces of the sequential list engine.
interface sle_in_if import sle_pkg::*;;
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [POS_W-1:0]    position;
  logic [DATA_W-1:0]   value;

  modport source (output valid, mode, position, value, input ready);
  modport sink   (input valid, mode, position, value, output ready);
endinterface

interface sle_out_if import sle_pkg::*;;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [DATA_W-1:0]   element;
  logic [POS_W-1:0]    found_position;
  logic [LEN_W-1:0]    list_length;
  logic                is_empty;

  modport source (output valid, status, element, found_position, list_length, is_empty,
                  input ready);
  modport sink   (input valid, status, element, found_position, list_length, is_empty,
                  output ready);
endinterface

// ===== sv/sequential_list_engine_core.sv =====
// Ordered byte list held in an on-chip memory with a length count.
// One request at a time: get reads the addressed element, locate scans from the
// front until a match or the end of the list, insert shifts the tail up from the
// end and then writes the value, and delete returns the element and shifts the
// tail down; rejected requests, clear and unknown modes go straight to the result.
// The walk runs one element per cycle through the single read / single write port
// of the element memory.
// A finished result sits in an output register, so a new request is taken while
// the previous result waits. No clearing pass after reset.
module sequential_list_engine_core import sle_pkg::*; #(
  parameter int CAPACITY = SLE_CAPACITY
) (
  input  logic          clk,
  input  logic          rst_n,
  sle_in_if.sink        in_ch,
  sle_out_if.source     out_ch
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);

  logic [DATA_W-1:0] mem [CAPACITY];

  sle_state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;
  logic [CW-1:0] pm1_r, pm1_nxt;
  logic          pend_r, pend_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  logic [DATA_W-1:0] rdata_r;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [DATA_W-1:0]   res_elem_r, res_elem_nxt;
  logic [POS_W-1:0]    res_found_r, res_found_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic [DATA_W-1:0]   out_elem_r;
  logic [POS_W-1:0]    out_found_r;
  logic [LEN_W-1:0]    out_len_r;
  logic                out_empty_r;
  logic                out_load;

  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [DATA_W-1:0] mem_wd;
  logic [AW-1:0] mem_ra;

  logic          in_xfer;
  logic [PW-1:0] pos_e, cnt_e;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign pos_e       = PW'(in_ch.position);
  assign cnt_e       = PW'(count_r);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    rd_idx_nxt     = rd_idx_r;
    pm1_nxt        = pm1_r;
    pend_nxt       = 1'b0;
    val_nxt        = val_r;
    res_status_nxt = res_status_r;
    res_elem_nxt   = res_elem_r;
    res_found_nxt  = res_found_r;
    mem_we         = 1'b0;
    mem_wa         = rd_idx_r[AW-1:0];
    mem_wd         = rdata_r;
    mem_ra         = idx_r[AW-1:0];
    out_load       = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          res_status_nxt = ST_OK;
          res_elem_nxt   = '0;
          res_found_nxt  = '0;
          val_nxt        = in_ch.value;
          pm1_nxt        = CW'(pos_e - PW'(1));
          state_nxt      = S_DONE;
          case (in_ch.mode)
            MODE_GET, MODE_DELETE: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end else if (pos_e == '0 || pos_e > cnt_e) begin
                res_status_nxt = ST_RANGE;
              end else begin
                idx_nxt   = CW'(pos_e - PW'(1));
                state_nxt = (in_ch.mode == MODE_GET) ? S_GET : S_DOWN;
              end
            end
            MODE_LOCATE: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                res_status_nxt = ST_NOTFOUND;
                idx_nxt        = '0;
                state_nxt      = S_SCAN;
              end
            end
            MODE_INSERT: begin
              if (cnt_e >= CAP_P) begin
                res_status_nxt = ST_FULL;
              end else if (pos_e == '0 || pos_e > cnt_e + PW'(1)) begin
                res_status_nxt = ST_RANGE;
              end else begin
                idx_nxt   = count_r;
                state_nxt = S_UP;
              end
            end
            MODE_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_GET: begin
        if (!pend_r) begin
          rd_idx_nxt = idx_r;
          pend_nxt   = 1'b1;
        end else begin
          res_elem_nxt = rdata_r;
          state_nxt    = S_DONE;
        end
      end

      S_SCAN: begin
        if (pend_r && rdata_r == val_r) begin
          res_status_nxt = ST_OK;
          res_found_nxt  = POS_W'(rd_idx_r + CW'(1));
          state_nxt      = S_DONE;
        end else if (idx_r == count_r) begin
          state_nxt = S_DONE;
        end else begin
          rd_idx_nxt = idx_r;
          pend_nxt   = 1'b1;
          idx_nxt    = idx_r + CW'(1);
        end
      end

      // shift up: read entry j, write it to j+1 on the next cycle, then drop the value in
      S_UP: begin
        mem_ra = AW'(idx_r - CW'(1));
        if (pend_r) begin
          mem_we = 1'b1;
          mem_wa = AW'(rd_idx_r + CW'(1));
          mem_wd = rdata_r;
        end else if (idx_r == pm1_r) begin
          mem_we    = 1'b1;
          mem_wa    = pm1_r[AW-1:0];
          mem_wd    = val_r;
          count_nxt = count_r + CW'(1);
          state_nxt = S_DONE;
        end
        if (idx_r != pm1_r) begin
          rd_idx_nxt = idx_r - CW'(1);
          pend_nxt   = 1'b1;
          idx_nxt    = idx_r - CW'(1);
        end
      end

      // shift down: first read returns the removed element, later ones move to j-1
      S_DOWN: begin
        if (pend_r) begin
          if (rd_idx_r == pm1_r) begin
            res_elem_nxt = rdata_r;
          end else begin
            mem_we = 1'b1;
            mem_wa = AW'(rd_idx_r - CW'(1));
            mem_wd = rdata_r;
          end
        end
        if (idx_r == count_r) begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_DONE;
        end else begin
          rd_idx_nxt = idx_r;
          pend_nxt   = 1'b1;
          idx_nxt    = idx_r + CW'(1);
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    rd_idx_r     <= rd_idx_nxt;
    pm1_r        <= pm1_nxt;
    val_r        <= val_nxt;
    res_status_r <= res_status_nxt;
    res_elem_r   <= res_elem_nxt;
    res_found_r  <= res_found_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_elem_r   <= res_elem_r;
      out_found_r  <= res_found_r;
      out_len_r    <= LEN_W'(count_r);
      out_empty_r  <= (count_r == '0);
    end
  end

  // element memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_r <= mem[mem_ra];
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.element        = out_elem_r;
  assign out_ch.found_position = out_found_r;
  assign out_ch.list_length    = out_len_r;
  assign out_ch.is_empty       = out_empty_r;

endmodule

// ===== sv/sle_checker.sv =====
// Port-level checks for the sequential list engine, bound to the top level.
module sle_checker import sle_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] out_status,
  input logic [DATA_W-1:0]   out_element,
  input logic [POS_W-1:0]    out_found_position,
  input logic [LEN_W-1:0]    out_list_length,
  input logic                out_is_empty
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_element)
      && $stable(out_found_position) && $stable(out_list_length))
    else $error("result changed while stalled");

  a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |-> out_list_length == '0)
    else $error("empty flag with nonzero length");

  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_element == '0 && out_found_position == '0)
    else $error("rejected request carries data");

  a_full_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> !out_is_empty)
    else $error("full status on empty list");

endmodule

bind sequential_list_engine_core sle_checker u_sle_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_status         (out_ch.status),
  .out_element        (out_ch.element),
  .out_found_position (out_ch.found_position),
  .out_list_length    (out_ch.list_length),
  .out_is_empty       (out_ch.is_empty)
);

// ===== verif/tb_sequential_list_engine_core.sv =====
// Self-checking testbench for the sequential list engine: random request traffic, scored results.
`timescale 1ns / 100ps

module tb_sequential_list_engine_core;
  import sle_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int TAIL_CYCLES = 100;
  localparam int RAND_ITEMS  = 650;

  // modes 5..7 do nothing
  localparam logic [MODE_W-1:0] MODE_NOP_A = 3'd5;
  localparam logic [MODE_W-1:0] MODE_NOP_B = 3'd6;
  localparam logic [MODE_W-1:0] MODE_NOP_C = 3'd7;

  localparam int PH_GROW   = 0;
  localparam int PH_MIX    = 1;
  localparam int PH_SHRINK = 2;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] value;
    logic              drain;  // hold this request until all results are back
  } list_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   element;
    logic [POS_W-1:0]    found_position;
    logic [LEN_W-1:0]    list_length;
    logic                is_empty;
  } list_result_t;

  logic clk;
  logic rst_n;

  sle_in_if  req_if ();
  sle_out_if rsp_if ();

  sequential_list_engine_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_if),
    .out_ch (rsp_if)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // list contents as the engine should hold them
  logic [DATA_W-1:0] list_mem [0:SLE_CAPACITY-1];
  int                list_len;

  list_req_t    pending_reqs [$];
  list_result_t expected_results [$];

  list_req_t    cur_req;
  logic         req_held;
  logic         req_fire;
  logic         valid_nx;
  int           src_gap;
  int           src_calm;

  logic         ready_nx;
  int           snk_stall;
  int           snk_calm;
  list_result_t got_res;
  list_result_t want_res;

  int           err_cnt;
  int           cycle_cnt;
  int           gen_len;
  int           phase;
  int           pick;
  int           hi;
  logic [MODE_W-1:0] gm;
  int           gp;
  logic [DATA_W-1:0] gv;

  function automatic list_result_t apply_list_op(list_req_t r);
    list_result_t res;
    int pos;
    int k;
    res = '0;
    pos = int'(r.position);
    case (r.mode)
      MODE_GET: begin
        if (list_len == 0) res.status = ST_EMPTY;
        else if (pos < 1 || pos > list_len) res.status = ST_RANGE;
        else res.element = list_mem[pos-1];
      end
      MODE_LOCATE: begin
        if (list_len == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.status = ST_NOTFOUND;
          for (k = 0; k < list_len; k++) begin
            if (list_mem[k] == r.value) begin
              res.found_position = POS_W'(k + 1);
              res.status = ST_OK;
              break;
            end
          end
        end
      end
      MODE_INSERT: begin
        if (list_len >= SLE_CAPACITY) begin
          res.status = ST_FULL;
        end else if (pos < 1 || pos > list_len + 1) begin
          res.status = ST_RANGE;
        end else begin
          for (k = list_len; k >= pos; k--) list_mem[k] = list_mem[k-1];
          list_mem[pos-1] = r.value;
          list_len++;
        end
      end
      MODE_DELETE: begin
        if (list_len == 0) begin
          res.status = ST_EMPTY;
        end else if (pos < 1 || pos > list_len) begin
          res.status = ST_RANGE;
        end else begin
          res.element = list_mem[pos-1];
          for (k = pos; k < list_len; k++) list_mem[k-1] = list_mem[k];
          list_len--;
        end
      end
      MODE_CLEAR: list_len = 0;
      default: ;
    endcase
    res.list_length = LEN_W'(list_len);
    res.is_empty    = (list_len == 0);
    return res;
  endfunction

  // mostly short idles, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(25, 70);
  endfunction

  // queue a request; gen_len follows the list length so positions can be aimed
  task automatic add_req(input logic [MODE_W-1:0] m, input int p,
                         input logic [DATA_W-1:0] v, input logic drain);
    list_req_t r;
    r.mode     = m;
    r.position = POS_W'(p);
    r.value    = v;
    r.drain    = drain;
    pending_reqs.push_back(r);
    case (m)
      MODE_INSERT: if (gen_len < SLE_CAPACITY && p >= 1 && p <= gen_len + 1) gen_len++;
      MODE_DELETE: if (gen_len > 0 && p >= 1 && p <= gen_len) gen_len--;
      MODE_CLEAR:  gen_len = 0;
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input list_result_t want,
                                 input list_result_t got);
    err_cnt++;
    if (err_cnt <= 10)
      $display("%s: expected st=%0d el=%02h fp=%0d len=%0d emp=%0b, got st=%0d el=%02h fp=%0d len=%0d emp=%0b",
               what, want.status, want.element, want.found_position, want.list_length,
               want.is_empty, got.status, got.element, got.found_position,
               got.list_length, got.is_empty);
  endtask

  // request driver
  always @(posedge clk) begin
    req_fire = req_if.valid && req_if.ready;
    valid_nx = req_if.valid;
    if (!rst_n) begin
      valid_nx = 1'b0;
    end else begin
      if (req_fire) begin
        expected_results.push_back(apply_list_op(cur_req));
        req_held = 1'b0;
        valid_nx = 1'b0;
        if (src_calm > 0) begin
          src_calm--;
          src_gap = 0;
        end else if ($urandom_range(0, 99) < 2) begin
          src_calm = $urandom_range(40, 150);
          src_gap = 0;
        end else begin
          src_gap = ($urandom_range(0, 99) < 40) ? idle_len() : 0;
        end
      end
      if (!req_held) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (pending_reqs.size() > 0 &&
                     !(pending_reqs[0].drain && expected_results.size() > 0)) begin
          cur_req = pending_reqs.pop_front();
          req_held = 1'b1;
          valid_nx = 1'b1;
          req_if.mode     <= cur_req.mode;
          req_if.position <= cur_req.position;
          req_if.value    <= cur_req.value;
        end
      end
    end
    req_if.valid <= valid_nx;
  end

  // result monitor and backpressure
  always @(posedge clk) begin
    ready_nx = 1'b0;
    if (rst_n) begin
      if (rsp_if.valid && rsp_if.ready) begin
        got_res.status         = rsp_if.status;
        got_res.element        = rsp_if.element;
        got_res.found_position = rsp_if.found_position;
        got_res.list_length    = rsp_if.list_length;
        got_res.is_empty       = rsp_if.is_empty;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", '0, got_res);
        end else begin
          want_res = expected_results.pop_front();
          if (got_res.status !== want_res.status ||
              got_res.element !== want_res.element ||
              got_res.found_position !== want_res.found_position ||
              got_res.list_length !== want_res.list_length ||
              got_res.is_empty !== want_res.is_empty)
            report_mismatch("mismatch", want_res, got_res);
        end
      end
      if (snk_stall > 0) begin
        snk_stall--;
      end else if (snk_calm > 0) begin
        snk_calm--;
        ready_nx = 1'b1;
      end else if ($urandom_range(0, 99) < 2) begin
        snk_calm = $urandom_range(40, 200);
        ready_nx = 1'b1;
      end else if ($urandom_range(0, 99) < 25) begin
        snk_stall = idle_len() - 1;
      end else begin
        ready_nx = 1'b1;
      end
    end
    rsp_if.ready <= ready_nx;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    req_if.valid = 1'b0;
    req_if.mode = '0;
    req_if.position = '0;
    req_if.value = '0;
    rsp_if.ready = 1'b0;
    req_held = 1'b0;
    src_gap = 0;
    src_calm = 0;
    snk_stall = 0;
    snk_calm = 0;
    err_cnt = 0;
    cycle_cnt = 0;
    list_len = 0;
    gen_len = 0;
    for (int i = 0; i < SLE_CAPACITY; i++) list_mem[i] = '0;

    // directed: empty-list rejects, range edges, front/middle/end insert, idle modes
    add_req(MODE_GET,    1,   8'h00, 1'b0);
    add_req(MODE_LOCATE, 0,   8'h00, 1'b0);
    add_req(MODE_DELETE, 1,   8'h00, 1'b0);
    add_req(MODE_INSERT, 0,   8'h07, 1'b0);
    add_req(MODE_INSERT, 2,   8'h07, 1'b0);
    add_req(MODE_INSERT, 1,   8'h00, 1'b0);
    add_req(MODE_INSERT, 1,   8'hFF, 1'b0);
    add_req(MODE_INSERT, 3,   8'hAA, 1'b0);
    add_req(MODE_INSERT, 2,   8'h55, 1'b0);
    add_req(MODE_GET,    0,   8'h00, 1'b0);
    add_req(MODE_GET,    1,   8'h00, 1'b0);
    add_req(MODE_GET,    4,   8'hFF, 1'b0);
    add_req(MODE_GET,    5,   8'h00, 1'b0);
    add_req(MODE_GET,    127, 8'h00, 1'b0);
    add_req(MODE_LOCATE, 127, 8'hAA, 1'b0);
    add_req(MODE_LOCATE, 1,   8'h12, 1'b0);
    add_req(MODE_DELETE, 0,   8'h00, 1'b0);
    add_req(MODE_DELETE, 5,   8'h00, 1'b0);
    add_req(MODE_DELETE, 2,   8'h00, 1'b0);
    add_req(MODE_DELETE, 3,   8'h00, 1'b0);
    add_req(MODE_NOP_A,  127, 8'hFF, 1'b1);
    add_req(MODE_NOP_B,  64,  8'h80, 1'b0);
    add_req(MODE_NOP_C,  1,   8'h01, 1'b0);
    add_req(MODE_CLEAR,  127, 8'hFF, 1'b0);
    add_req(MODE_GET,    1,   8'h00, 1'b0);

    // random: grow/shrink phases so the list reaches both full and empty
    for (int n = 0; n < RAND_ITEMS; n++) begin
      case (n / 130)
        0, 3:    phase = PH_GROW;
        2, 4:    phase = PH_SHRINK;
        default: phase = PH_MIX;
      endcase
      pick = $urandom_range(0, 99);
      if (pick < ((phase == PH_GROW) ? 65 : (phase == PH_MIX) ? 35 : 20)) begin
        gm = MODE_INSERT;
      end else if (pick < ((phase == PH_GROW) ? 75 : (phase == PH_MIX) ? 60 : 65)) begin
        gm = MODE_DELETE;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 45) gm = MODE_GET;
        else if (pick < 90) gm = MODE_LOCATE;
        else if (pick < 96) gm = MODE_NOP_A + MODE_W'($urandom_range(0, 2));
        else gm = MODE_CLEAR;
      end
      hi = (gm == MODE_INSERT) ? gen_len + 1 : ((gen_len > 0) ? gen_len : 1);
      pick = $urandom_range(0, 99);
      if (pick < 80) gp = $urandom_range(1, hi);
      else if (pick < 86) gp = 0;
      else if (pick < 93) gp = hi + 1;
      else gp = $urandom_range(0, 127);
      // a small alphabet half the time so locate finds matches
      gv = ($urandom_range(0, 1) != 0) ? DATA_W'($urandom_range(0, 3) * 85)
                                       : DATA_W'($urandom_range(0, 255));
      add_req(gm, gp, gv, (n == 200 || n == 450));
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || req_held || expected_results.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (err_cnt == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
